/* sv/assert_macros.svh */
// Assertion helpers for the LZW decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/lzwd_pkg.sv */
// ---------------------------------------------------------------------------
// lzwd_pkg
// Types, constants and helpers shared by the LZW decoder modules.
// ---------------------------------------------------------------------------
package lzwd_pkg;

  localparam int MAX_CODE_WIDTH = 12;
  localparam int TABLE_DEPTH    = 4096;
  localparam int ADDR_W         = $clog2(TABLE_DEPTH);
  localparam int CODE_W         = MAX_CODE_WIDTH;
  localparam int NEXT_W         = CODE_W + 1;
  localparam int DEPTH_W        = ADDR_W + 1;
  localparam int BUF_W          = 24;
  localparam int HELD_W         = 5;
  localparam int MIN_WIDTH      = 9;
  localparam int TABLE_LIMIT    = (TABLE_DEPTH < (1 << MAX_CODE_WIDTH)) ?
                                  TABLE_DEPTH : (1 << MAX_CODE_WIDTH);
  localparam int CODE_CLEAR     = 256;
  localparam int CODE_END       = 257;
  localparam int FIRST_FREE     = 258;
  localparam int PUSH_MAX_HELD  = 16;

  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_PULL    = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_UNKNOWN = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_PUSH_OK  = 3'd1,
    ST_NEED     = 3'd2,
    ST_END      = 3'd3,
    ST_BAD_CODE = 3'd4,
    ST_REJECT   = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] in_byte;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       last_of_string;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PULL,
    S_CLASS,
    S_WALK_A,
    S_WALK_B,
    S_POP
  } fsm_state_t;

  typedef struct packed {
    logic    push_byte;
    logic    restart;
    logic    take_code;
    logic    clear_tab;
    logic    set_fin;
    logic    start_walk;
    logic    walk_rd;
    logic    walk_step;
    logic    push_root;
    logic    pop_rd;
    logic    emit;
    status_t emit_status;
  } cmd_t;

  typedef struct packed {
    logic stack_empty;
    logic finished;
    logic input_ended;
    logic push_full;
    logic starved;
    logic code_clear;
    logic code_end;
    logic code_bad;
    logic cur_root;
  } sts_t;

  // code width is the bit length of next_code+1, clamped
  function automatic logic [HELD_W-1:0] code_width(input logic [NEXT_W-1:0] nc);
    logic [NEXT_W:0]       v;
    logic [HELD_W-1:0]     w;
    v = {1'b0, nc} + (NEXT_W+1)'(1);
    w = HELD_W'(MIN_WIDTH);
    for (int k = MIN_WIDTH + 1; k <= MAX_CODE_WIDTH; k++) begin
      if (v >= (NEXT_W+1)'(1 << (k - 1))) w = HELD_W'(k);
    end
    return w;
  endfunction

endpackage

/* sv/lzwd_ctrl.sv */
// ---------------------------------------------------------------------------
// lzwd_ctrl
// Sequencer: request dispatch, code fetch, string walk and byte pop.
// ---------------------------------------------------------------------------
module lzwd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [1:0]          req_type,
  input  logic                out_free,
  input  lzwd_pkg::sts_t      sts,
  output logic                req_stall,
  output lzwd_pkg::cmd_t      cmd
);

  lzwd_pkg::fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzwd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_stall  = 1'b1;
    unique case (state)
      lzwd_pkg::S_IDLE: begin
        req_stall = !out_free;
        if (req_valid && out_free) begin
          unique case (lzwd_pkg::req_kind_t'(req_type))
            lzwd_pkg::REQ_PUSH: begin
              cmd.emit = 1'b1;
              if (sts.push_full) begin
                cmd.emit_status = lzwd_pkg::ST_REJECT;
              end else begin
                cmd.push_byte   = 1'b1;
                cmd.emit_status = lzwd_pkg::ST_PUSH_OK;
              end
            end
            lzwd_pkg::REQ_PULL: begin
              state_next = lzwd_pkg::S_PULL;
            end
            lzwd_pkg::REQ_RESTART: begin
              cmd.restart     = 1'b1;
              cmd.emit        = 1'b1;
              cmd.emit_status = lzwd_pkg::ST_NEED;
            end
            default: begin
              cmd.emit        = 1'b1;
              cmd.emit_status = lzwd_pkg::ST_REJECT;
            end
          endcase
        end
      end
      lzwd_pkg::S_PULL: begin
        if (out_free) begin
          priority if (!sts.stack_empty) begin
            cmd.pop_rd = 1'b1;
            state_next = lzwd_pkg::S_POP;
          end else if (sts.finished) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = lzwd_pkg::ST_END;
            state_next      = lzwd_pkg::S_IDLE;
          end else if (sts.starved) begin
            cmd.emit        = 1'b1;
            cmd.set_fin     = sts.input_ended;
            cmd.emit_status = sts.input_ended ? lzwd_pkg::ST_END : lzwd_pkg::ST_NEED;
            state_next      = lzwd_pkg::S_IDLE;
          end else begin
            cmd.take_code = 1'b1;
            state_next    = lzwd_pkg::S_CLASS;
          end
        end
      end
      lzwd_pkg::S_CLASS: begin
        if (out_free) begin
          priority if (sts.code_clear) begin
            cmd.clear_tab = 1'b1;
            state_next    = lzwd_pkg::S_PULL;
          end else if (sts.code_end || sts.code_bad) begin
            cmd.set_fin     = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_status = sts.code_end ? lzwd_pkg::ST_END : lzwd_pkg::ST_BAD_CODE;
            state_next      = lzwd_pkg::S_IDLE;
          end else begin
            cmd.start_walk = 1'b1;
            state_next     = lzwd_pkg::S_WALK_A;
          end
        end
      end
      lzwd_pkg::S_WALK_A: begin
        if (sts.cur_root) begin
          cmd.push_root = 1'b1;
          state_next    = lzwd_pkg::S_PULL;
        end else begin
          cmd.walk_rd = 1'b1;
          state_next  = lzwd_pkg::S_WALK_B;
        end
      end
      lzwd_pkg::S_WALK_B: begin
        cmd.walk_step = 1'b1;
        state_next    = lzwd_pkg::S_WALK_A;
      end
      lzwd_pkg::S_POP: begin
        if (out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = lzwd_pkg::ST_BYTE;
          state_next      = lzwd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lzwd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* sv/lzwd_dp.sv */
// ---------------------------------------------------------------------------
// lzwd_dp
// Bit buffer, string table, expansion stack and result register.
// ---------------------------------------------------------------------------
module lzwd_dp (
  input  logic             clk,
  input  logic             rst,
  input  lzwd_pkg::cmd_t   cmd,
  input  lzwd_pkg::req_t   req,
  input  logic             rsp_stall,
  output logic             rsp_valid,
  output lzwd_pkg::rsp_t   rsp,
  output logic             out_free,
  output lzwd_pkg::sts_t   sts
);

  localparam int CW = lzwd_pkg::CODE_W;
  localparam int NW = lzwd_pkg::NEXT_W;
  localparam int AW = lzwd_pkg::ADDR_W;
  localparam int DW = lzwd_pkg::DEPTH_W;
  localparam int BW = lzwd_pkg::BUF_W;
  localparam int HW = lzwd_pkg::HELD_W;

  logic [CW-1:0] prefix_mem [lzwd_pkg::TABLE_DEPTH];
  logic [7:0]    suffix_mem [lzwd_pkg::TABLE_DEPTH];
  logic [7:0]    stack_mem  [lzwd_pkg::TABLE_DEPTH];

  logic [BW-1:0] bit_buf;
  logic [HW-1:0] held;
  logic [NW-1:0] next_code;
  logic [CW-1:0] prev_code;
  logic          have_prev;
  logic [7:0]    prev_first;
  logic [DW-1:0] depth;
  logic          input_ended;
  logic          finished;
  logic [CW-1:0] code;
  logic [CW-1:0] cur;
  logic [CW-1:0] pre_q;
  logic [7:0]    suf_q;
  logic [7:0]    stk_q;

  logic [HW-1:0] width;
  logic [HW-1:0] held_rem;
  logic [BW-1:0] shifted;
  logic [CW-1:0] code_x;
  logic [BW-1:0] buf_masked;
  logic          kwk;
  logic          add_entry;
  logic          stk_we;
  logic [7:0]    stk_wdata;

  assign width      = lzwd_pkg::code_width(next_code);
  assign held_rem   = held - width;
  assign shifted    = bit_buf >> held_rem;
  assign code_x     = shifted[CW-1:0] & CW'((32'd1 << width) - 32'd1);
  assign buf_masked = bit_buf & ((BW'(1) << held_rem) - BW'(1));
  assign kwk        = ({1'b0, code} == next_code);
  assign add_entry  = cmd.push_root && have_prev &&
                      (next_code < NW'(lzwd_pkg::TABLE_LIMIT));

  assign sts.stack_empty = (depth == '0);
  assign sts.finished    = finished;
  assign sts.input_ended = input_ended;
  assign sts.push_full   = (held > HW'(lzwd_pkg::PUSH_MAX_HELD)) || input_ended || finished;
  assign sts.starved     = (held < width);
  assign sts.code_clear  = (code == CW'(lzwd_pkg::CODE_CLEAR));
  assign sts.code_end    = (code == CW'(lzwd_pkg::CODE_END));
  assign sts.code_bad    = ({1'b0, code} > next_code) ||
                           (kwk && (!have_prev ||
                                    next_code >= NW'(lzwd_pkg::TABLE_LIMIT)));
  assign sts.cur_root    = (cur < CW'(lzwd_pkg::FIRST_FREE));

  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      bit_buf     <= '0;
      held        <= '0;
      next_code   <= NW'(lzwd_pkg::FIRST_FREE);
      prev_code   <= '0;
      have_prev   <= 1'b0;
      depth       <= '0;
      input_ended <= 1'b0;
      finished    <= 1'b0;
    end else begin
      if (cmd.push_byte) begin
        bit_buf <= {bit_buf[BW-9:0], req.in_byte};
        held    <= held + HW'(8);
        if (req.last_byte) input_ended <= 1'b1;
      end
      if (cmd.take_code) begin
        held    <= held_rem;
        bit_buf <= buf_masked;
      end
      if (cmd.clear_tab) begin
        next_code <= NW'(lzwd_pkg::FIRST_FREE);
        have_prev <= 1'b0;
      end
      if (cmd.set_fin) finished <= 1'b1;
      if (cmd.start_walk && kwk) depth <= depth + DW'(1);
      if (cmd.walk_step) depth <= depth + DW'(1);
      if (cmd.push_root) begin
        depth      <= depth + DW'(1);
        prev_code  <= code;
        have_prev  <= 1'b1;
        if (add_entry) next_code <= next_code + NW'(1);
      end
      if (cmd.pop_rd) depth <= depth - DW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_code) code <= code_x;
    if (cmd.start_walk) cur <= kwk ? prev_code : code;
    if (cmd.walk_step) cur <= pre_q;
    if (cmd.push_root) prev_first <= cur[7:0];
  end

  // string table
  always_ff @(posedge clk) begin
    if (cmd.walk_rd) begin
      pre_q <= prefix_mem[cur[AW-1:0]];
      suf_q <= suffix_mem[cur[AW-1:0]];
    end
    if (add_entry) begin
      prefix_mem[next_code[AW-1:0]] <= prev_code;
      suffix_mem[next_code[AW-1:0]] <= cur[7:0];
    end
  end

  // expansion stack; KwKwK pushes the previous string's first byte below it
  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = cur[7:0];
    priority if (cmd.start_walk && kwk) begin
      stk_we    = 1'b1;
      stk_wdata = prev_first;
    end else if (cmd.walk_step) begin
      stk_we    = 1'b1;
      stk_wdata = suf_q;
    end else if (cmd.push_root) begin
      stk_we    = 1'b1;
      stk_wdata = cur[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[depth[AW-1:0]] <= stk_wdata;
    if (cmd.pop_rd) stk_q <= stack_mem[AW'(depth - DW'(1))];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status <= cmd.emit_status;
      if (cmd.emit_status == lzwd_pkg::ST_BYTE) begin
        rsp.out_byte       <= stk_q;
        rsp.last_of_string <= (depth == '0);
      end else begin
        rsp.out_byte       <= '0;
        rsp.last_of_string <= 1'b0;
      end
    end
  end

endmodule

/* sv/lzw_decompressor_msb_early_change.sv */
// ---------------------------------------------------------------------------
// lzw_decompressor_msb_early_change
// LZW decoder, MSB-first codes of 9 to 12 bits with early width change.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries push, pull or restart items;
//   rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one item for each.
//   Push, restart and unknown requests answer on the cycle after acceptance.
//   A pull served from the expansion stack passes S_PULL (stack read) and
//   S_POP; one that must fetch a new code also passes S_CLASS, S_WALK_A and
//   S_WALK_B per table entry on the code's prefix chain (one registered
//   table read per link), S_WALK_A and S_PULL at the root, and S_PULL and
//   S_CLASS again for each clear code met on the way. Throughput: push, restart
//   and unknown items can be taken every cycle. A new item is taken only
//   while the sequencer is idle and the result register is free or draining.
//   Reset clears the bit buffer, counters and flags at once; the table and
//   stack memories are not cleared and need no sweep.
//   While rsp_stall is high the pending result holds and req_stall stays
//   high until it is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lzw_decompressor_msb_early_change (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  lzwd_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output lzwd_pkg::rsp_t  rsp
);

  lzwd_pkg::cmd_t cmd;
  lzwd_pkg::sts_t sts;
  logic           out_free;

  lzwd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .out_free  (out_free),
    .sts       (sts),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  lzwd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .out_free  (out_free),
    .sts       (sts)
  );

  `AST_NOW(a_nonbyte_zero, clk, rst, rsp_valid && (rsp.status != lzwd_pkg::ST_BYTE), (rsp.out_byte == 8'd0) && !rsp.last_of_string)
  `AST_NEXT(a_restart_rsp, clk, rst, req_valid && !req_stall && (req.req_type == lzwd_pkg::REQ_RESTART), rsp_valid && (rsp.status == lzwd_pkg::ST_NEED))
  `AST_NOW(a_emit_free, clk, rst, cmd.emit, out_free)

endmodule
